// ===== rtl/core/kpcp_pkg.sv =====
// Shared constants, codes and types of the keyed Pearson counter generator.
package kpcp_pkg;

   localparam int MAX_LIMBS     = 8;
   localparam int MAX_KEY_BYTES = 32;
   localparam int DROP_STEPS    = 3072;

   localparam int BYTE_W        = 8;
   localparam int TABLE_DEPTH   = 1 << BYTE_W;
   localparam int POSITION_W    = 64;
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_WORDS     = 4;
   localparam int KEY_LEN_W     = 6;
   localparam int KIND_W        = 2;
   localparam int CSR_INDEX_W   = 3;

   localparam int POS_BITS      = MAX_LIMBS * BYTE_W;
   localparam int LIMB_COUNT_W  = $clog2(MAX_LIMBS + 1);
   localparam int LIMB_INDEX_W  = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
   localparam int KEY_INDEX_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int STEP_W        = $clog2(DROP_STEPS);

   localparam logic [BYTE_W-1:0] TABLE_LAST = BYTE_W'(TABLE_DEPTH - 1);
   localparam logic [STEP_W-1:0] DROP_LAST  = STEP_W'(DROP_STEPS - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_REKEY    = 2'd0,
      KIND_SEEK     = 2'd1,
      KIND_GENERATE = 2'd2
   } kind_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ_I,
      ST_READ_J,
      ST_WRITE_I,
      ST_WRITE_J,
      ST_GEN_START,
      ST_GEN_HASH,
      ST_GEN_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } pos_ctrl_type;

endpackage

// ===== rtl/core/kpcp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module kpcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kpcp_position.sv =====
// Stream position counter: seek load, limb count and increment with carry.
module kpcp_position (
   input  logic                                clock,
   input  logic                                reset,
   input  kpcp_pkg::pos_ctrl_type              ctrl,
   input  logic [kpcp_pkg::POSITION_W-1:0]     seek_position,
   input  logic [kpcp_pkg::LIMB_INDEX_W-1:0]   byte_index,
   output logic [kpcp_pkg::BYTE_W-1:0]         pos_byte,
   output logic [kpcp_pkg::LIMB_COUNT_W-1:0]   used_limbs
);

   import kpcp_pkg::*;

   logic [POS_BITS-1:0]     pos_ff;
   logic [POS_BITS-1:0]     pos_in;
   logic [LIMB_COUNT_W-1:0] limbs_ff;
   logic [LIMB_COUNT_W-1:0] limbs_in;
   logic [POS_BITS-1:0]     seek_bits;
   logic [LIMB_COUNT_W-1:0] seek_limbs;
   logic                    used_all_ones;

   assign seek_bits = seek_position[POS_BITS-1:0];

   always_comb begin
      seek_limbs = LIMB_COUNT_W'(1);
      for (int k = 0; k < MAX_LIMBS; k++) begin
         if (seek_bits[k*BYTE_W +: BYTE_W] != '0) begin
            seek_limbs = LIMB_COUNT_W'(k + 1);
         end
      end
   end

   always_comb begin
      used_all_ones = 1'b1;
      for (int k = 0; k < MAX_LIMBS; k++) begin
         if ((LIMB_COUNT_W'(k) < limbs_ff) && (pos_ff[k*BYTE_W +: BYTE_W] != '1)) begin
            used_all_ones = 1'b0;
         end
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      limbs_in = limbs_ff;
      if (ctrl.load) begin
         pos_in   = seek_bits;
         limbs_in = seek_limbs;
      end else if (ctrl.advance) begin
         pos_in = pos_ff + POS_BITS'(1);
         if (used_all_ones && (limbs_ff < LIMB_COUNT_W'(MAX_LIMBS))) begin
            limbs_in = limbs_ff + LIMB_COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         limbs_ff <= LIMB_COUNT_W'(1);
      end else begin
         pos_ff   <= pos_in;
         limbs_ff <= limbs_in;
      end
   end

   assign pos_byte   = pos_ff[{byte_index, 3'b000} +: BYTE_W];
   assign used_limbs = limbs_ff;

endmodule

// ===== rtl/core/keyed_pearson_counter_prng_unit.sv =====
// Top level of the keyed Pearson counter byte generator with its sequencer and table.
// A seek item, or an item of the unused kind, leaves the sequencer idle and the block ready
// again in the next cycle. A generate item holds the input side from acceptance through the
// start, hash and done states, and the result item is registered as it leaves the done state;
// the chain of dependent lookups through the single read port of the table sets this, one
// lookup per cycle. A rekey item holds the input side while the fill state writes the
// identity permutation into all 256 entries, then through 256 key schedule and 3072 drop
// steps, each in four states (read i, read j, write i, write j) on the table. The result
// register lets a waiting result item stand while new items are accepted; a generate
// item waits at its end only while that register still holds an untaken item.
module keyed_pearson_counter_prng_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kpcp_pkg::KIND_W-1:0]         req_kind,
   input  logic [kpcp_pkg::POSITION_W-1:0]     req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kpcp_pkg::BYTE_W-1:0]         rsp_random_byte,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpcp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kpcp_pkg::KEY_WORD_W-1:0]     csr_data
);

   import kpcp_pkg::*;

   state_type state_ff, state_in;

   logic [KEY_WORD_W-1:0]  key_word_ff [KEY_WORDS];
   logic [KEY_LEN_W-1:0]   key_length_ff;

   logic [BYTE_W-1:0]       i_ff, i_in;
   logic [BYTE_W-1:0]       j_ff, j_in;
   logic [BYTE_W-1:0]       si_ff, si_in;
   logic [KEY_INDEX_W-1:0]  kidx_ff, kidx_in;
   logic [STEP_W-1:0]       steps_ff, steps_in;
   logic                    drop_ff, drop_in;
   logic                    keyed_ff, keyed_in;
   logic [LIMB_COUNT_W-1:0] k_ff, k_in;
   logic [BYTE_W-1:0]       hash_ff, hash_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;

   logic                    ram_we;
   logic [BYTE_W-1:0]       ram_waddr;
   logic [BYTE_W-1:0]       ram_wdata;
   logic [BYTE_W-1:0]       ram_raddr;
   logic [BYTE_W-1:0]       ram_rd_data;

   pos_ctrl_type            pos_ctrl;
   logic [LIMB_INDEX_W-1:0] pos_index;
   logic [BYTE_W-1:0]       pos_byte;
   logic [LIMB_COUNT_W-1:0] used_limbs;

   logic [KEY_WORDS*KEY_WORD_W-1:0] key_flat;
   logic [BYTE_W-1:0]       key_byte;
   logic [KEY_LEN_W-1:0]    key_len_eff;
   logic                    key_wrap;
   logic [BYTE_W-1:0]       addend;
   logic [BYTE_W-1:0]       step_j;
   logic [BYTE_W-1:0]       table_byte;
   logic                    rsp_slot_free;

   kpcp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   kpcp_position u_position (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (pos_ctrl),
      .seek_position (req_position),
      .byte_index    (pos_index),
      .pos_byte      (pos_byte),
      .used_limbs    (used_limbs)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < KEY_WORDS; w++) begin
            key_word_ff[w] <= '0;
         end
         key_length_ff <= KEY_LEN_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index) inside
            CSR_KEY_WORD_0, CSR_KEY_WORD_1, CSR_KEY_WORD_2, CSR_KEY_WORD_3: begin
               key_word_ff[csr_index[1:0]] <= csr_data;
            end
            CSR_KEY_LENGTH: begin
               key_length_ff <= csr_data[KEY_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int w = 0; w < KEY_WORDS; w++) begin
         key_flat[w*KEY_WORD_W +: KEY_WORD_W] = key_word_ff[w];
      end
   end

   assign key_byte = key_flat[{kidx_ff, 3'b000} +: BYTE_W];

   always_comb begin
      if (key_length_ff == '0) begin
         key_len_eff = KEY_LEN_W'(1);
      end else if (key_length_ff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         key_len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         key_len_eff = key_length_ff;
      end
   end

   assign key_wrap      = (KEY_LEN_W'(kidx_ff) + KEY_LEN_W'(1)) >= key_len_eff;
   assign addend        = drop_ff ? '0 : key_byte;
   assign step_j        = j_ff + ram_rd_data + addend;
   assign table_byte    = keyed_ff ? ram_rd_data : '0;
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_REKEY:    state_in = ST_FILL;
                  KIND_GENERATE: state_in = ST_GEN_START;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            if (i_ff == TABLE_LAST) begin
               state_in = ST_READ_I;
            end
         end
         ST_READ_I:  state_in = ST_READ_J;
         ST_READ_J:  state_in = ST_WRITE_I;
         ST_WRITE_I: state_in = ST_WRITE_J;
         ST_WRITE_J: begin
            if (drop_ff && (steps_ff == DROP_LAST)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_I;
            end
         end
         ST_GEN_START: state_in = ST_GEN_HASH;
         ST_GEN_HASH: begin
            if (k_ff == used_limbs) begin
               state_in = ST_GEN_DONE;
            end
         end
         ST_GEN_DONE: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      kidx_in      = kidx_ff;
      steps_in     = steps_ff;
      drop_in      = drop_ff;
      keyed_in     = keyed_ff;
      k_in         = k_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      ram_we       = 1'b0;
      ram_waddr    = i_ff;
      ram_wdata    = i_ff;
      ram_raddr    = i_ff;
      pos_ctrl     = '0;
      pos_index    = k_ff[LIMB_INDEX_W-1:0];
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_REKEY:    i_in = '0;
                  KIND_SEEK:     pos_ctrl.load = 1'b1;
                  KIND_GENERATE: k_in = '0;
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            ram_we = 1'b1;
            i_in   = i_ff + BYTE_W'(1);
            if (i_ff == TABLE_LAST) begin
               keyed_in = 1'b1;
               j_in     = '0;
               kidx_in  = '0;
               drop_in  = 1'b0;
            end
         end
         ST_READ_I: begin
            ram_raddr = i_ff;
         end
         ST_READ_J: begin
            j_in      = step_j;
            si_in     = ram_rd_data;
            ram_raddr = step_j;
         end
         ST_WRITE_I: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rd_data;
         end
         ST_WRITE_J: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = si_ff;
            i_in      = i_ff + BYTE_W'(1);
            if (drop_ff) begin
               steps_in = steps_ff + STEP_W'(1);
            end else begin
               kidx_in = key_wrap ? '0 : kidx_ff + KEY_INDEX_W'(1);
               if (i_ff == TABLE_LAST) begin
                  drop_in  = 1'b1;
                  i_in     = BYTE_W'(1);
                  j_in     = '0;
                  steps_in = '0;
               end
            end
         end
         ST_GEN_START: begin
            ram_raddr = pos_byte;
            k_in      = LIMB_COUNT_W'(1);
         end
         ST_GEN_HASH: begin
            ram_raddr = table_byte ^ pos_byte;
            if (k_ff == used_limbs) begin
               hash_in = table_byte;
            end else begin
               k_in = k_ff + LIMB_COUNT_W'(1);
            end
         end
         ST_GEN_DONE: begin
            if (rsp_slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_byte_in      = hash_ff;
               pos_ctrl.advance = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         kidx_ff      <= '0;
         steps_ff     <= '0;
         drop_ff      <= 1'b0;
         keyed_ff     <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         kidx_ff      <= kidx_in;
         steps_ff     <= steps_in;
         drop_ff      <= drop_in;
         keyed_ff     <= keyed_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      hash_ff     <= hash_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_byte = rsp_byte_ff;

endmodule

// ===== rtl/core/kpcp_checker.sv =====
// Port-level assertions for the keyed Pearson counter generator and their bind.
module kpcp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [kpcp_pkg::KIND_W-1:0]         req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [kpcp_pkg::BYTE_W-1:0]         rsp_random_byte
);

   import kpcp_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_byte))
      else $error("A stalled result item changed or was dropped.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_GENERATE) |=> !req_ready ##1 !req_ready)
      else $error("A generate item did not hold off the next item.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_REKEY) |=> !req_ready ##2 !req_ready)
      else $error("A rekey item did not hold off the next item.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_SEEK) |=> req_ready)
      else $error("A seek item did not return to ready in the next cycle.");

endmodule

bind keyed_pearson_counter_prng_unit kpcp_checker u_kpcp_checker (.*);

// ===== tb/sv/keyed_pearson_counter_prng_unit_test.sv =====
// Self-checking testbench of the keyed Pearson counter byte generator.
module keyed_pearson_counter_prng_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kpcp_pkg::*;

   localparam logic [KIND_W-1:0]      KIND_UNUSED    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST = 3'd7;
   localparam int REKEY_MARGIN = 1 + TABLE_DEPTH + 4 * (TABLE_DEPTH + DROP_STEPS) + 64;
   localparam int SHORT_MARGIN = 16;
   localparam int PHASE_ITEMS  = 210;
   localparam int REPORT_LIMIT = 10;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [KIND_W-1:0]       req_kind;
   logic [POSITION_W-1:0]   req_position;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [BYTE_W-1:0]       rsp_random_byte;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [KEY_WORD_W-1:0]   csr_data;

   logic [BYTE_W-1:0]     sbox_model [TABLE_DEPTH];
   logic [BYTE_W-1:0]     position_model [MAX_LIMBS];
   int                    limbs_model;
   logic [KEY_WORD_W-1:0] key_model [KEY_WORDS];
   logic [KEY_LEN_W-1:0]  key_len_model;

   logic [BYTE_W-1:0] expected_bytes [$];
   logic [BYTE_W-1:0] wanted_byte;
   int                mismatches = 0;
   int                busy_margin = SHORT_MARGIN;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   keyed_pearson_counter_prng_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_byte (rsp_random_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result item: random_byte %02h", rsp_random_byte);
         end else begin
            wanted_byte = expected_bytes.pop_front();
            if (rsp_random_byte !== wanted_byte) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("random_byte mismatch: expected %02h, actual %02h",
                           wanted_byte, rsp_random_byte);
            end
         end
      end
   end

   function automatic void rebuild_sbox();
      int len, i, j, kidx, n;
      logic [BYTE_W-1:0] t;
      len = int'(key_len_model);
      if (len < 1) len = 1;
      if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
      for (i = 0; i < TABLE_DEPTH; i++) sbox_model[i] = BYTE_W'(i);
      j = 0;
      kidx = 0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         j = (j + sbox_model[i] + key_model[kidx / 8][(kidx % 8) * 8 +: 8]) % TABLE_DEPTH;
         kidx++;
         if (kidx >= len) kidx = 0;
         t = sbox_model[i];
         sbox_model[i] = sbox_model[j];
         sbox_model[j] = t;
      end
      i = 0;
      j = 0;
      for (n = 0; n < DROP_STEPS; n++) begin
         i = (i + 1) % TABLE_DEPTH;
         j = (j + sbox_model[i]) % TABLE_DEPTH;
         t = sbox_model[i];
         sbox_model[i] = sbox_model[j];
         sbox_model[j] = t;
      end
   endfunction

   function automatic void load_position(input logic [POSITION_W-1:0] position);
      int k, n;
      n = 1;
      for (k = 0; k < MAX_LIMBS; k++) begin
         position_model[k] = position[k * 8 +: 8];
         if (position_model[k] != 0) n = k + 1;
      end
      limbs_model = n;
   endfunction

   function automatic logic [BYTE_W-1:0] next_random_byte();
      logic [BYTE_W-1:0] h;
      int k;
      logic carry;
      h = '0;
      for (k = 0; k < limbs_model; k++) h = sbox_model[h ^ position_model[k]];
      k = 0;
      carry = 1'b1;
      while (carry) begin
         position_model[k] = position_model[k] + 8'd1;
         if (position_model[k] != 0) begin
            carry = 1'b0;
         end else begin
            k++;
            if (k == limbs_model) begin
               if (limbs_model < MAX_LIMBS) begin
                  position_model[k] = 8'd1;
                  limbs_model++;
               end
               carry = 1'b0;
            end
         end
      end
      return h;
   endfunction

   function automatic logic [POSITION_W-1:0] random_position();
      logic [POSITION_W-1:0] value, mask;
      int nbytes;
      value = {$urandom, $urandom};
      nbytes = $urandom_range(MAX_LIMBS, 0);
      mask = (64'd1 << (8 * nbytes)) - 64'd1;
      if ($urandom_range(3, 0) == 0)
         return mask & ~64'($urandom_range(3, 0));
      return value & mask;
   endfunction

   function automatic logic [KEY_WORD_W-1:0] random_key_word();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [POSITION_W-1:0] position);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_position <= position;
      do @(posedge clock); while (!req_ready);
      busy_margin = SHORT_MARGIN;
      case (kind)
         KIND_REKEY: begin
            rebuild_sbox();
            busy_margin = REKEY_MARGIN;
         end
         KIND_SEEK: load_position(position);
         KIND_GENERATE: expected_bytes.push_back(next_random_byte());
         default: ;
      endcase
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (busy_margin) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [KEY_WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_KEY_LENGTH) key_len_model = data[KEY_LEN_W-1:0];
      else if (index <= CSR_KEY_WORD_3) key_model[index[1:0]] = data;
   endtask

   task automatic program_key(input logic [KEY_WORD_W-1:0] w0, w1, w2, w3, length);
      int idx;
      settle();
      write_register(CSR_KEY_WORD_0, w0);
      write_register(CSR_KEY_WORD_1, w1);
      write_register(CSR_KEY_WORD_2, w2);
      write_register(CSR_KEY_WORD_3, w3);
      write_register(CSR_KEY_LENGTH, length);
      for (idx = int'(CSR_KEY_LENGTH) + 1; idx <= int'(CSR_INDEX_LAST); idx++)
         write_register(CSR_INDEX_W'(idx), random_key_word());
      csr_valid <= 1'b0;
   endtask

   task automatic test_unkeyed_table();
      send_item(KIND_GENERATE, '1);
      send_item(KIND_GENERATE, '0);
   endtask

   task automatic test_key_length_limits();
      logic [KEY_WORD_W-1:0] w0, w1, w2, w3;
      w0 = {$urandom, $urandom};
      w1 = {$urandom, $urandom};
      w2 = {$urandom, $urandom};
      w3 = {$urandom, $urandom};
      program_key('1, '1, '1, '1, 64'd0);
      send_item(KIND_REKEY, '1);
      send_item(KIND_GENERATE, '0);
      program_key(w0, w1, w2, w3, 64'd32);
      send_item(KIND_REKEY, '0);
      send_item(KIND_GENERATE, '1);
      program_key(w0, w1, w2, w3, 64'd63);
      send_item(KIND_REKEY, {$urandom, $urandom});
      send_item(KIND_GENERATE, {$urandom, $urandom});
   endtask

   task automatic test_counter_carry();
      send_item(KIND_SEEK, 64'hff);
      send_item(KIND_GENERATE, '0);
      send_item(KIND_GENERATE, '0);
      send_item(KIND_SEEK, '1);
      send_item(KIND_GENERATE, '0);
      send_item(KIND_GENERATE, '1);
      send_item(KIND_SEEK, '0);
      send_item(KIND_GENERATE, '1);
      send_item(KIND_SEEK, 64'h0100_0000_0000_0000);
      send_item(KIND_GENERATE, '0);
   endtask

   task automatic test_unused_kind();
      send_item(KIND_UNUSED, {$urandom, $urandom});
      send_item(KIND_GENERATE, '0);
   endtask

   task automatic test_random_streams();
      int mode, phase, counted, run, k, roll;
      logic [KEY_WORD_W-1:0] length;
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 88;
            end
            1: begin
               send_idle_pct = 88;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (phase = 0; phase < 3; phase++) begin
            length = {$urandom, $urandom};
            case (mode * 3 + phase)
               0: length[KEY_LEN_W-1:0] = 6'd1;
               1: length[KEY_LEN_W-1:0] = 6'd32;
               2: length[KEY_LEN_W-1:0] = 6'd0;
               3: length[KEY_LEN_W-1:0] = 6'd63;
               4: length[KEY_LEN_W-1:0] = 6'd33;
               default: ;
            endcase
            program_key(random_key_word(), random_key_word(), random_key_word(),
                        random_key_word(), length);
            send_item(KIND_REKEY, {$urandom, $urandom});
            counted = 1;
            while (counted < PHASE_ITEMS) begin
               roll = $urandom_range(99);
               if (roll < 4) begin
                  send_item(KIND_UNUSED, {$urandom, $urandom});
               end else if (roll < 5) begin
                  send_item(KIND_REKEY, {$urandom, $urandom});
                  counted++;
               end else begin
                  if (roll >= 15) begin
                     send_item(KIND_SEEK, random_position());
                     counted++;
                  end
                  run = $urandom_range(6, 1);
                  for (k = 0; k < run; k++)
                     send_item(KIND_GENERATE, {$urandom, $urandom});
                  counted += run;
               end
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_GENERATE;
      req_position = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_WORD_0;
      csr_data = '0;
      foreach (sbox_model[i]) sbox_model[i] = '0;
      foreach (position_model[i]) position_model[i] = '0;
      foreach (key_model[i]) key_model[i] = '0;
      limbs_model = 1;
      key_len_model = 6'd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 88;
      test_unkeyed_table();
      test_key_length_limits();
      test_counter_carry();
      test_unused_kind();
      test_random_streams();
      settle();
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

endmodule
